// File: hw/rtl/fqi_pkg.sv
package fqi_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // fixed field widths
  localparam int OP_W   = 2;
  localparam int POS_W  = 7;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 7;

  localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

  localparam logic signed [DATA_W-1:0] NO_WORD = -32'sd1;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_POP
  } cmd_kind_t;

  // broadcast to every cell in the row
  typedef struct packed {
    cmd_kind_t                 kind;
    logic [IDX_W-1:0]          slot;
    logic signed [DATA_W-1:0]  value;
  } cell_cmd_t;

endpackage

// File: hw/rtl/fqi_if.sv
interface fqi_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [fqi_pkg::OP_W-1:0]              op;
  logic [fqi_pkg::POS_W-1:0]             position;
  logic signed [fqi_pkg::DATA_W-1:0]     value;

  modport source (output valid, op, position, value, input ready);
  modport sink   (input valid, op, position, value, output ready);
endinterface

interface fqi_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [fqi_pkg::DATA_W-1:0]     popped_value;
  logic [fqi_pkg::STAT_W-1:0]            status;
  logic [fqi_pkg::OCC_W-1:0]             occupancy;

  modport source (output valid, popped_value, status, occupancy, input ready);
  modport sink   (input valid, popped_value, status, occupancy, output ready);
endinterface

// File: hw/rtl/fqi_cell.sv
module fqi_cell (
  input  logic                              clk,
  input  logic [fqi_pkg::IDX_W-1:0]         idx,
  input  fqi_pkg::cell_cmd_t                cmd,
  input  logic signed [fqi_pkg::DATA_W-1:0] prev_data,
  input  logic signed [fqi_pkg::DATA_W-1:0] next_data,
  output logic signed [fqi_pkg::DATA_W-1:0] data
);
  import fqi_pkg::*;

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  // insert: the slot loads the new word, everything behind moves back one;
  // pop: everything moves forward one
  always_comb begin
    data_nxt = data_r;
    case (cmd.kind)
      CMD_INSERT: begin
        if (idx == cmd.slot) begin
          data_nxt = cmd.value;
        end else if (idx > cmd.slot) begin
          data_nxt = prev_data;
        end
      end
      CMD_POP:  data_nxt = next_data;
      default:  data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// File: hw/rtl/fifo_queue_with_positional_insert.sv
// Ordered queue of signed 32-bit words held in a row of DEPTH cells, front in
// cell 0. Push appends, pop removes the front, insert places a word at a 1-based
// position and moves the later words back. Every cell shifts, holds or loads in
// the same cycle, so a request is taken every cycle and its result word appears
// in the output register on the next cycle; the only stall is a full output
// register while out_if.ready is low. No clearing pass after reset.
module fifo_queue_with_positional_insert (
  input  logic clk,
  input  logic rst_n,
  fqi_req_if.sink   in_if,
  fqi_rsp_if.source out_if
);
  import fqi_pkg::*;

  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  logic [CNT_W-1:0]          count_r, count_nxt;
  logic                      out_valid_r;
  logic signed [DATA_W-1:0]  popped_r, popped_nxt;
  logic [STAT_W-1:0]         status_r, status_nxt;
  logic [OCC_W-1:0]          occ_r;
  logic                      accept;
  logic                      full, empty;
  logic [CMP_W-1:0]          pos_ext, limit;
  logic [POS_W-1:0]          pos_m1;
  cell_cmd_t                 cmd;
  logic signed [DATA_W-1:0]  cell_data [DEPTH];

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign pos_ext = CMP_W'(in_if.position);
  assign limit   = CMP_W'(count_r) + CMP_W'(1);
  assign pos_m1  = in_if.position - POS_W'(1);

  always_comb begin
    cmd.kind   = CMD_HOLD;
    cmd.slot   = count_r[IDX_W-1:0];
    cmd.value  = in_if.value;
    count_nxt  = count_r;
    popped_nxt = NO_WORD;
    status_nxt = ST_OK;
    unique case (in_if.op)
      OP_PUSH: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          cmd.kind  = CMD_INSERT;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          cmd.kind   = CMD_POP;
          popped_nxt = cell_data[0];
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      OP_INSERT: begin
        // position check wins over full
        if (pos_ext == '0 || pos_ext > limit) begin
          status_nxt = ST_INVALID;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          cmd.kind  = CMD_INSERT;
          cmd.slot  = IDX_W'(pos_m1);
          count_nxt = count_r + CNT_W'(1);
        end
      end
      default: status_nxt = ST_INVALID;
    endcase
    if (!accept) begin
      cmd.kind = CMD_HOLD;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] prev_w, next_w;
    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid_p
      assign prev_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_w = cell_data[i];
    end else begin : g_mid_n
      assign next_w = cell_data[i+1];
    end
    fqi_cell u_cell (
      .clk       (clk),
      .idx       (IDX_W'(i)),
      .cmd       (cmd),
      .prev_data (prev_w),
      .next_data (next_w),
      .data      (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      popped_r <= popped_nxt;
      status_r <= status_nxt;
      occ_r    <= OCC_W'(count_nxt);
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.popped_value = popped_r;
  assign out_if.status       = status_r;
  assign out_if.occupancy    = occ_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("count above depth");

  a_word_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("no result word after accepted request");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_if.op == OP_POP && empty |=>
      status_r == ST_EMPTY && popped_r == NO_WORD && $stable(count_r))
    else $error("empty pop mishandled");

  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_if.op == OP_PUSH && full |=> status_r == ST_FULL && $stable(count_r))
    else $error("push into full queue mishandled");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(count_r))
    else $error("count moved without a request");

endmodule
